// File: hw/rtl/qaas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaas_pkg
// Shared types, constants and the CORDIC arctangent table for the
// quaternion axis-angle spin controller.
// ----------------------------------------------------------------------------
package qaas_pkg;

   // CORDIC vectoring steps and counter width
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_IDX_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   // Angle constants in Q4.12
   localparam logic signed [17:0] PI_Q12      = 18'sd12868;
   localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;

   // ms to s scale (1000) times Q16.16 over Q4.12 (16)
   localparam logic signed [17:0] RATE_SCALE = 18'sd16000;

   // Register reset values
   localparam logic [15:0] ANGLE_GAIN_RESET = 16'd4608;
   localparam logic [15:0] RATE_GAIN_RESET  = 16'd0;
   localparam logic [9:0]  PERIOD_RESET     = 10'd10;

   // Register indexes
   localparam logic [1:0] CSR_ANGLE_GAIN = 2'd0;
   localparam logic [1:0] CSR_RATE_GAIN  = 2'd1;
   localparam logic [1:0] CSR_PERIOD     = 2'd2;

   // Command to the shared root / divide unit
   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } unit_cmd_type;

   // Arctangent of 2^-i in Q4.24
   function automatic logic signed [27:0] atan_step(input logic [4:0] idx);
      logic signed [27:0] val;
      begin
         case (idx)
            5'd0:    val = 28'sd13176795;
            5'd1:    val = 28'sd7778716;
            5'd2:    val = 28'sd4110060;
            5'd3:    val = 28'sd2086331;
            5'd4:    val = 28'sd1047214;
            5'd5:    val = 28'sd524117;
            5'd6:    val = 28'sd262123;
            5'd7:    val = 28'sd131069;
            5'd8:    val = 28'sd65536;
            5'd9:    val = 28'sd32768;
            default: begin
               if (idx <= 5'd24) begin
                  val = 28'sd1 <<< (5'd24 - idx);
               end else begin
                  val = 28'sd0;
               end
            end
         endcase
         return val;
      end
   endfunction

endpackage

// File: hw/rtl/qaas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaas_req_if / qaas_rsp_if
// Valid/ready channels carrying quaternion requests and spin results.
// ----------------------------------------------------------------------------
interface qaas_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source (output valid, output quat_x, output quat_y, output quat_z,
                   output quat_w, input ready);
   modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                   input quat_w, output ready);
endinterface

interface qaas_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] spin_x;
   logic signed [31:0] spin_y;
   logic signed [31:0] spin_z;
   logic signed [15:0] unwrapped_angle;
   logic signed [31:0] angle_rate;
   logic               saturated;

   modport source (output valid, output spin_x, output spin_y, output spin_z,
                   output unwrapped_angle, output angle_rate, output saturated,
                   input ready);
   modport sink   (input valid, input spin_x, input spin_y, input spin_z,
                   input unwrapped_angle, input angle_rate, input saturated,
                   output ready);
endinterface

// File: hw/rtl/qaas_root_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qaas_root_div
// Shared shift-subtract unit: one bit per cycle of unsigned 64/16 division
// or of a 32-bit integer square root.
// ----------------------------------------------------------------------------
module qaas_root_div (
   input  logic                  clock,
   input  logic                  reset,
   input  qaas_pkg::unit_cmd_type cmd,
   input  logic [63:0]           operand,
   input  logic [15:0]           divisor,
   output logic                  done,
   output logic [63:0]           result
);

   logic [63:0] acc_ff;
   logic [63:0] res_ff;
   logic [19:0] rem_ff;
   logic [15:0] div_ff;
   logic [6:0]  cnt_ff;
   logic        run_ff;
   logic        sqrt_ff;
   logic        done_ff;

   logic [19:0] rem_sh;
   logic [19:0] trial;
   logic [20:0] diff;
   logic        ge;

   // Bring in next dividend bit or radicand bit pair, trial subtract
   always_comb begin
      if (sqrt_ff) begin
         rem_sh = {rem_ff[17:0], acc_ff[63:62]};
         trial  = {res_ff[17:0], 2'b01};
      end else begin
         rem_sh = {rem_ff[18:0], acc_ff[63]};
         trial  = {4'd0, div_ff};
      end
      diff = {1'b0, rem_sh} - {1'b0, trial};
      ge   = ~diff[20];
   end

   // Sequence the iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         // flag the last iteration
         done_ff <= !cmd.start && run_ff && (cnt_ff == 7'd1);
         if (cmd.start) begin
            run_ff  <= 1'b1;
            sqrt_ff <= cmd.sqrt_mode;
            acc_ff  <= cmd.sqrt_mode ? {operand[31:0], 32'd0} : operand;
            res_ff  <= 64'd0;
            rem_ff  <= 20'd0;
            div_ff  <= divisor;
            cnt_ff  <= cmd.sqrt_mode ? 7'd16 : 7'd64;
         end else if (run_ff) begin
            acc_ff <= sqrt_ff ? {acc_ff[61:0], 2'b00} : {acc_ff[62:0], 1'b0};
            rem_ff <= ge ? diff[19:0] : rem_sh;
            res_ff <= {res_ff[62:0], ge};
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// File: hw/rtl/quat_axis_angle_spin_control_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quat_axis_angle_spin_control_top
// Converts an orientation quaternion into an axis-angle spin command with
// angle unwrapping, angle rate and proportional gains.
// ----------------------------------------------------------------------------
// One request at a time: a quaternion goes through 2 square roots and 4
// divisions on the shared root/divide unit, a CORDIC arctangent and the
// sequencing steps, and the request side is not ready meanwhile.
// A finished result sits in an output register, so the next request is
// taken while it waits to be read. The user must write the gains and the
// loop period through the csr port only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module quat_axis_angle_spin_control_top (
   input  logic        clock,
   input  logic        reset,
   qaas_req_if.sink    req_if,
   qaas_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CORDIC_IDX_W_L = qaas_pkg::CORDIC_IDX_W;

   typedef enum logic [4:0] {
      ST_IDLE, ST_SQ_W, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SUM,
      ST_ROOT_S, ST_ROOT_M, ST_CORDIC, ST_ANGLE, ST_MUL_DIFF,
      ST_RATE_GO, ST_RATE_WAIT, ST_MUL_AG, ST_MUL_RG, ST_FACTOR,
      ST_MUL_LO, ST_MUL_HI, ST_SPIN_GO, ST_SPIN_WAIT, ST_DONE
   } state_type;

   state_type state_ff;

   // Configuration
   logic [15:0] angle_gain_ff;
   logic [15:0] rate_gain_ff;
   logic [9:0]  period_ff;

   // Request and intermediate values
   logic signed [15:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [15:0] prev_ff;
   logic signed [51:0] prod_ff;
   logic [31:0]        rad_ff;
   logic [31:0]        sum_ff;
   logic [14:0]        s_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [27:0] ph_ff;
   logic [CORDIC_IDX_W_L-1:0] ci_ff;
   logic signed [17:0] ang_ff;
   logic signed [18:0] diff_ff;
   logic               rneg_ff;
   logic signed [31:0] rate_ff;
   logic signed [49:0] fa_ff;
   logic [48:0]        fmag_ff;
   logic               fneg_ff;
   logic [41:0]        plo_ff;
   logic [1:0]         cidx_ff;
   logic signed [31:0] spin_ff [3];
   logic               sat_ff;

   // Shared unit command
   logic               ustart_ff;
   logic               ustart_in;
   logic               usqrt_ff;
   logic [63:0]        uop_ff;
   logic [15:0]        udiv_ff;
   qaas_pkg::unit_cmd_type ucmd;
   logic               udone;
   logic [63:0]        ures;

   // Output register
   logic               rsp_valid_ff;
   logic signed [31:0] out_sx_ff, out_sy_ff, out_sz_ff, out_rate_ff;
   logic signed [15:0] out_ang_ff;
   logic               out_sat_ff;

   // Start the shared unit on leaving each launch state
   always_comb begin
      case (state_ff)
         ST_SUM, ST_RATE_GO, ST_SPIN_GO: ustart_in = 1'b1;
         ST_ROOT_S:                      ustart_in = udone;
         default:                        ustart_in = 1'b0;
      endcase
   end

   // ------------------------------------------------------------------
   // Shared multiplier operand select
   // ------------------------------------------------------------------
   logic signed [33:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [51:0] prod_in;
   logic signed [16:0] comp;
   logic               comp_neg;
   logic [16:0]        comp_mag;

   always_comb begin
      case (cidx_ff)
         2'd0:    comp = 17'(qx_ff);
         2'd1:    comp = -17'(qy_ff);
         default: comp = -17'(qz_ff);
      endcase
      comp_neg = comp[16];
      comp_mag = comp_neg ? 17'(-comp) : 17'(comp);
   end

   always_comb begin
      case (state_ff)
         ST_SQ_W: begin
            mul_a = 34'(qw_ff);
            mul_b = 18'(qw_ff);
         end
         ST_SQ_X: begin
            mul_a = 34'(qx_ff);
            mul_b = 18'(qx_ff);
         end
         ST_SQ_Y: begin
            mul_a = 34'(qy_ff);
            mul_b = 18'(qy_ff);
         end
         ST_SQ_Z: begin
            mul_a = 34'(qz_ff);
            mul_b = 18'(qz_ff);
         end
         ST_MUL_DIFF: begin
            mul_a = 34'(diff_ff);
            mul_b = qaas_pkg::RATE_SCALE;
         end
         ST_MUL_AG: begin
            mul_a = 34'(ang_ff);
            mul_b = $signed({2'b00, angle_gain_ff});
         end
         ST_MUL_RG: begin
            mul_a = 34'(rate_ff);
            mul_b = $signed({2'b00, rate_gain_ff});
         end
         ST_MUL_LO: begin
            mul_a = $signed({9'd0, fmag_ff[24:0]});
            mul_b = $signed({1'b0, comp_mag});
         end
         ST_MUL_HI: begin
            mul_a = $signed({10'd0, fmag_ff[48:25]});
            mul_b = $signed({1'b0, comp_mag});
         end
         default: begin
            mul_a = 34'sd0;
            mul_b = 18'sd0;
         end
      endcase
   end

   assign prod_in = 52'(mul_a) * 52'(mul_b);

   // ------------------------------------------------------------------
   // CORDIC step, angle rounding and unwrap
   // ------------------------------------------------------------------
   logic signed [35:0] dx, dy;
   logic signed [27:0] step_ang;
   logic signed [27:0] ph_pos;
   logic [16:0]        angm;
   logic signed [17:0] ang_raw;
   logic signed [17:0] prev_s;
   logic signed [17:0] ang_unw;
   logic               w_neg;
   logic [16:0]        w_mag;

   always_comb begin
      dx       = cy_ff >>> ci_ff;
      dy       = cx_ff >>> ci_ff;
      step_ang = qaas_pkg::atan_step(5'(ci_ff));
      ph_pos   = ph_ff[27] ? 28'sd0 : ph_ff;
      angm     = 17'((ph_pos + 28'sd1024) >>> 11);
      w_neg    = qw_ff[15];
      w_mag    = (qw_ff == 16'sd0) ? 17'd1 :
                 (w_neg ? 17'(-17'(qw_ff)) : 17'(17'(qw_ff)));
      ang_raw  = w_neg ? -$signed({1'b0, angm}) : $signed({1'b0, angm});
      prev_s   = 18'(prev_ff);
      if (ang_raw < prev_s - qaas_pkg::HALF_PI_Q12) begin
         ang_unw = ang_raw + qaas_pkg::PI_Q12;
      end else if (ang_raw > prev_s + qaas_pkg::HALF_PI_Q12) begin
         ang_unw = ang_raw - qaas_pkg::PI_Q12;
      end else begin
         ang_unw = ang_raw;
      end
   end

   // ------------------------------------------------------------------
   // Helper values from the product register and the unit result
   // ------------------------------------------------------------------
   logic [51:0]        prod_mag;
   logic signed [49:0] factor;
   logic [63:0]        spin_num;
   logic               spin_neg;
   logic               spin_sat;
   logic signed [31:0] spin_val;

   always_comb begin
      prod_mag = prod_ff[51] ? 52'(-prod_ff) : 52'(prod_ff);
      factor   = fa_ff + 50'(prod_ff);
      spin_num = 64'(plo_ff) + (64'(prod_ff[40:0]) << 25);
      spin_neg = comp_neg ^ fneg_ff;
      if (spin_neg) begin
         spin_sat = (ures[63:31] != 33'd0) &&
                    !((ures[63:31] == 33'd1) && (ures[30:0] == 31'd0));
         spin_val = spin_sat ? 32'sh80000000 : -$signed(ures[31:0]);
      end else begin
         spin_sat = (ures[63:31] != 33'd0);
         spin_val = spin_sat ? 32'sh7fffffff : $signed(ures[31:0]);
      end
   end

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_gain_ff <= qaas_pkg::ANGLE_GAIN_RESET;
         rate_gain_ff  <= qaas_pkg::RATE_GAIN_RESET;
         period_ff     <= qaas_pkg::PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            qaas_pkg::CSR_ANGLE_GAIN: angle_gain_ff <= csr_wdata;
            qaas_pkg::CSR_RATE_GAIN:  rate_gain_ff  <= csr_wdata;
            qaas_pkg::CSR_PERIOD:     period_ff     <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= 16'sd0;
         ustart_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ustart_ff <= ustart_in;
         prod_ff   <= prod_in;

         // drop the result once taken, unless a new one loads now
         if (rsp_valid_ff && rsp_if.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  qx_ff    <= req_if.quat_x;
                  qy_ff    <= req_if.quat_y;
                  qz_ff    <= req_if.quat_z;
                  qw_ff    <= req_if.quat_w;
                  sat_ff   <= 1'b0;
                  state_ff <= ST_SQ_W;
               end
            end
            ST_SQ_W: state_ff <= ST_SQ_X;
            ST_SQ_X: begin
               rad_ff   <= (prod_ff >= 52'sd268435456) ? 32'd0 :
                           32'(52'sd268435456 - prod_ff);
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               sum_ff   <= prod_ff[31:0];
               state_ff <= ST_SQ_Z;
            end
            ST_SQ_Z: begin
               sum_ff   <= sum_ff + prod_ff[31:0];
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               sum_ff    <= sum_ff + prod_ff[31:0];
               usqrt_ff  <= 1'b1;
               uop_ff    <= {32'd0, rad_ff};
               state_ff  <= ST_ROOT_S;
            end
            ST_ROOT_S: begin
               if (udone) begin
                  s_ff      <= (ures[14:0] == 15'd0) ? 15'd1 : ures[14:0];
                  usqrt_ff  <= 1'b1;
                  uop_ff    <= {32'd0, sum_ff};
                  state_ff  <= ST_ROOT_M;
               end
            end
            ST_ROOT_M: begin
               if (udone) begin
                  cx_ff    <= $signed({3'd0, w_mag, 16'd0});
                  cy_ff    <= $signed({4'd0, ures[15:0], 16'd0});
                  ph_ff    <= 28'sd0;
                  ci_ff    <= '0;
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               // rotate toward the x axis, one step per cycle
               if (!cy_ff[35]) begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  ph_ff <= ph_ff + step_ang;
               end else begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  ph_ff <= ph_ff - step_ang;
               end
               ci_ff <= ci_ff + CORDIC_IDX_W_L'(1);
               if (ci_ff == CORDIC_IDX_W_L'(qaas_pkg::CORDIC_STEPS - 1)) begin
                  state_ff <= ST_ANGLE;
               end
            end
            ST_ANGLE: begin
               ang_ff   <= ang_unw;
               diff_ff  <= 19'(ang_unw) - 19'(prev_s);
               prev_ff  <= ang_unw[15:0];
               state_ff <= ST_MUL_DIFF;
            end
            ST_MUL_DIFF: state_ff <= ST_RATE_GO;
            ST_RATE_GO: begin
               rneg_ff   <= prod_ff[51];
               usqrt_ff  <= 1'b0;
               uop_ff    <= 64'(prod_mag);
               udiv_ff   <= (period_ff == 10'd0) ? 16'd1 : {6'd0, period_ff};
               state_ff  <= ST_RATE_WAIT;
            end
            ST_RATE_WAIT: begin
               if (udone) begin
                  rate_ff  <= rneg_ff ? -$signed(ures[31:0]) : $signed(ures[31:0]);
                  state_ff <= ST_MUL_AG;
               end
            end
            ST_MUL_AG: state_ff <= ST_MUL_RG;
            ST_MUL_RG: begin
               fa_ff    <= 50'(prod_ff) <<< 4;
               state_ff <= ST_FACTOR;
            end
            ST_FACTOR: begin
               fneg_ff  <= factor[49];
               fmag_ff  <= factor[49] ? 49'(-factor) : 49'(factor);
               cidx_ff  <= 2'd0;
               state_ff <= ST_MUL_LO;
            end
            ST_MUL_LO: state_ff <= ST_MUL_HI;
            ST_MUL_HI: begin
               plo_ff   <= prod_ff[41:0];
               state_ff <= ST_SPIN_GO;
            end
            ST_SPIN_GO: begin
               usqrt_ff  <= 1'b0;
               uop_ff    <= spin_num >> 8;
               udiv_ff   <= {1'd0, s_ff};
               state_ff  <= ST_SPIN_WAIT;
            end
            ST_SPIN_WAIT: begin
               if (udone) begin
                  spin_ff[cidx_ff] <= spin_val;
                  if (spin_sat) begin
                     sat_ff <= 1'b1;
                  end
                  if (cidx_ff == 2'd2) begin
                     state_ff <= ST_DONE;
                  end else begin
                     cidx_ff  <= cidx_ff + 2'd1;
                     state_ff <= ST_MUL_LO;
                  end
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_if.ready) begin
                  out_sx_ff    <= spin_ff[0];
                  out_sy_ff    <= spin_ff[1];
                  out_sz_ff    <= spin_ff[2];
                  out_ang_ff   <= ang_ff[15:0];
                  out_rate_ff  <= rate_ff;
                  out_sat_ff   <= sat_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Shared root / divide unit
   // ------------------------------------------------------------------
   assign ucmd.start     = ustart_ff;
   assign ucmd.sqrt_mode = usqrt_ff;

   qaas_root_div u_root_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ucmd),
      .operand (uop_ff),
      .divisor (udiv_ff),
      .done    (udone),
      .result  (ures)
   );

   // Ports
   assign req_if.ready           = (state_ff == ST_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.spin_x          = out_sx_ff;
   assign rsp_if.spin_y          = out_sy_ff;
   assign rsp_if.spin_z          = out_sz_ff;
   assign rsp_if.unwrapped_angle = out_ang_ff;
   assign rsp_if.angle_rate      = out_rate_ff;
   assign rsp_if.saturated       = out_sat_ff;

`ifndef SYNTH
   // unit finishes only while the sequencer waits on it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      udone |-> (state_ff == ST_ROOT_S || state_ff == ST_ROOT_M ||
                 state_ff == ST_RATE_WAIT || state_ff == ST_SPIN_WAIT))
      else $error("root/divide unit finished outside a wait state");

   // an accepted request closes the request side
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request side still ready after accept");

   // spin divisor is never zero
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPIN_GO) |-> (s_ff != 15'd0))
      else $error("zero spin divisor");
`endif

endmodule

// File: sim/quat_axis_angle_spin_control_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quat_axis_angle_spin_control_checker
// Watches the request and result channels and the register port, predicts
// each spin result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module quat_axis_angle_spin_control_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_x,
   input  logic [15:0] req_y,
   input  logic [15:0] req_z,
   input  logic [15:0] req_w,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_spin_x,
   input  logic [31:0] rsp_spin_y,
   input  logic [31:0] rsp_spin_z,
   input  logic [15:0] rsp_angle,
   input  logic [31:0] rsp_rate,
   input  logic        rsp_sat,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   typedef struct packed {
      logic [31:0] spin_x;
      logic [31:0] spin_y;
      logic [31:0] spin_z;
      logic [15:0] angle;
      logic [31:0] rate;
      logic        sat;
   } spin_result_type;

   spin_result_type expected_spins[$];
   logic [15:0] gain_angle, gain_rate;
   logic [9:0]  period_ms;
   logic [15:0] last_angle;

   assign pending_count = expected_spins.size();

   function automatic longint isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint clip32(longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint cordic_half(longint xin, longint yin);
      longint cx, cy, ph, dx, dy;
      cx = xin * 65536;
      cy = yin * 65536;
      ph = 0;
      for (int i = 0; i < qaas_pkg::CORDIC_STEPS && i < 63; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy >= 0) begin
            cx += dx; cy -= dy; ph += longint'(qaas_pkg::atan_step(5'(i)));
         end else begin
            cx -= dx; cy += dy; ph -= longint'(qaas_pkg::atan_step(5'(i)));
         end
      end
      return (ph < 0) ? 0 : ph;
   endfunction

   // Predict one result and advance the angle history
   function automatic spin_result_type predict_spin(logic [15:0] qx, logic [15:0] qy,
                                                    logic [15:0] qz, logic [15:0] qw);
      longint x, y, z, w, w2, d, s, mag, wc, ang, prv, rate, factor, den, per;
      bit flag;
      spin_result_type r;
      x = longint'($signed(qx));
      y = longint'($signed(qy));
      z = longint'($signed(qz));
      w = longint'($signed(qw));
      flag = 0;
      w2 = w * w;
      d = (w2 >= (64'sd1 << 28)) ? 0 : (64'sd1 << 28) - w2;
      s = isqrt(d);
      if (s < 1) s = 1;
      mag = isqrt(x * x + y * y + z * z);
      wc = (w == 0) ? 1 : w;
      ang = (cordic_half(wc < 0 ? -wc : wc, mag) + 1024) >>> 11;
      if (wc < 0) ang = -ang;
      prv = longint'($signed(last_angle));
      if (ang < prv - qaas_pkg::HALF_PI_Q12) ang += qaas_pkg::PI_Q12;
      else if (ang > prv + qaas_pkg::HALF_PI_Q12) ang -= qaas_pkg::PI_Q12;
      per = (period_ms == 0) ? 1 : longint'(period_ms);
      rate = clip32(((ang - prv) * 16000) / per, flag);
      factor = ang * longint'(gain_angle) * 16 + rate * longint'(gain_rate);
      den = s * 256;
      r.spin_x = 32'(clip32((x * factor) / den, flag));
      r.spin_y = 32'(clip32((-y * factor) / den, flag));
      r.spin_z = 32'(clip32((-z * factor) / den, flag));
      r.angle = 16'(ang);
      r.rate = 32'(rate);
      r.sat = flag;
      last_angle = 16'(ang);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %0h expected %0h",
               result_count, what, got, want);
      fail_count++;
   endtask

   // Track registers, predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      spin_result_type exp_r;
      if (reset) begin
         gain_angle <= qaas_pkg::ANGLE_GAIN_RESET;
         gain_rate <= qaas_pkg::RATE_GAIN_RESET;
         period_ms <= qaas_pkg::PERIOD_RESET;
         last_angle = 16'd0;
         expected_spins.delete();
         fail_count = 0;
         result_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               qaas_pkg::CSR_ANGLE_GAIN: gain_angle <= csr_wdata;
               qaas_pkg::CSR_RATE_GAIN:  gain_rate <= csr_wdata;
               qaas_pkg::CSR_PERIOD:     period_ms <= csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_spins.push_back(predict_spin(req_x, req_y, req_z, req_w));
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_spins.size() == 0) begin
               $display("unexpected result %0d", result_count);
               fail_count++;
            end else begin
               exp_r = expected_spins.pop_front();
               if (rsp_spin_x !== exp_r.spin_x)
                  report_mismatch("spin_x", rsp_spin_x, exp_r.spin_x);
               if (rsp_spin_y !== exp_r.spin_y)
                  report_mismatch("spin_y", rsp_spin_y, exp_r.spin_y);
               if (rsp_spin_z !== exp_r.spin_z)
                  report_mismatch("spin_z", rsp_spin_z, exp_r.spin_z);
               if (rsp_angle !== exp_r.angle)
                  report_mismatch("unwrapped_angle", 32'(rsp_angle), 32'(exp_r.angle));
               if (rsp_rate !== exp_r.rate)
                  report_mismatch("angle_rate", rsp_rate, exp_r.rate);
               if (rsp_sat !== exp_r.sat)
                  report_mismatch("saturated", 32'(rsp_sat), 32'(exp_r.sat));
            end
         end
      end
   end
endmodule

// File: sim/quat_axis_angle_spin_control_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quat_axis_angle_spin_control_top_test
// Drives quaternion requests through several gain and period settings with
// random gaps on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module quat_axis_angle_spin_control_top_test;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 400;

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int fail_count, pending_count, result_count;
   int idle_cycles = 0;
   int sent_count = 0;
   bit hold_rsp = 0;

   qaas_req_if req_if ();
   qaas_rsp_if rsp_if ();

   quat_axis_angle_spin_control_top u_top (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata));

   quat_axis_angle_spin_control_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready),
      .req_x(req_if.quat_x), .req_y(req_if.quat_y),
      .req_z(req_if.quat_z), .req_w(req_if.quat_w),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
      .rsp_spin_x(rsp_if.spin_x), .rsp_spin_y(rsp_if.spin_y),
      .rsp_spin_z(rsp_if.spin_z), .rsp_angle(rsp_if.unwrapped_angle),
      .rsp_rate(rsp_if.angle_rate), .rsp_sat(rsp_if.saturated),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_if.valid = 0;
      req_if.quat_x = '0;
      req_if.quat_y = '0;
      req_if.quat_z = '0;
      req_if.quat_w = '0;
      rsp_if.ready = 0;
   end

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
   endfunction

   // Drop ready at random, with one long hold-off while requests keep coming
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 0;
            repeat (3000) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_if.ready <= 1;
         n = $urandom_range(1, 12);
         repeat (n) @(posedge clock);
         if ($urandom_range(0, 2) == 0) begin
            n = gap_len();
            if (n > 0) begin
               rsp_if.ready <= 0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   // Count cycles with no handshake and end a stuck run
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", pending_count);
         $display("quat_axis_angle_spin_control_top_test: FAIL");
         $finish;
      end
   end

   // Offer one request and hold it until accepted; valid stays up afterward
   // so that a gapless request follows back to back
   task automatic send_quat(logic [15:0] qx, logic [15:0] qy,
                            logic [15:0] qz, logic [15:0] qw, bit gaps);
      int n;
      if (gaps) begin
         n = gap_len();
         if (n > 0) begin
            req_if.valid <= 0;
            repeat (n) @(posedge clock);
         end
      end
      req_if.valid <= 1;
      req_if.quat_x <= qx;
      req_if.quat_y <= qy;
      req_if.quat_z <= qz;
      req_if.quat_w <= qw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
   endtask

   // Stop offering and wait for every expected result
   task automatic wait_idle();
      req_if.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_comp();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 16'($urandom);
      if (k == 1) return 16'sd16384;
      if (k == 2) return -16'sd16384;
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // Random unit-ish quaternion with random signs, else raw noise
   task automatic send_random(bit gaps);
      int k;
      real ax, ay, az, aw, nrm;
      k = $urandom_range(0, 9);
      if (k < 7) begin
         ax = $urandom_range(0, 2000) - 1000.0;
         ay = $urandom_range(0, 2000) - 1000.0;
         az = $urandom_range(0, 2000) - 1000.0;
         aw = $urandom_range(0, 2000) - 1000.0;
         nrm = $sqrt(ax * ax + ay * ay + az * az + aw * aw) + 1.0;
         send_quat(16'($rtoi(ax * 16384.0 / nrm)), 16'($rtoi(ay * 16384.0 / nrm)),
                   16'($rtoi(az * 16384.0 / nrm)), 16'($rtoi(aw * 16384.0 / nrm)), gaps);
      end else begin
         send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), gaps);
      end
   endtask

   initial begin
      logic [15:0] ag [4];
      logic [15:0] rg [4];
      logic [15:0] pr [4];
      ag = '{16'd4608, 16'd0, 16'd65535, 16'd256};
      rg = '{16'd0, 16'd65535, 16'd128, 16'd1};
      pr = '{16'd10, 16'd1, 16'd1000, 16'd0};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: identity, extremes, zero w, norm above one, flips
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384, 0);
      send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 0);
      send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 0);
      send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 0);
      send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384, 0);
      send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384, 0);
      send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0);
      send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0);
      send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 0);
      send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 0);
      send_quat(16'sd11585, 16'sd0, 16'sd0, -16'sd11585, 0);
      send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd16383, 0);
      send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
      send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd1, 0);
      wait_idle();

      // Phases over register settings, including an unknown index
      for (int p = 0; p < 4; p++) begin
         write_reg(qaas_pkg::CSR_ANGLE_GAIN, ag[p]);
         write_reg(qaas_pkg::CSR_RATE_GAIN, rg[p]);
         write_reg(qaas_pkg::CSR_PERIOD, pr[p]);
         if (p == 2) write_reg(2'd3, 16'hFFFF);
         for (int i = 0; i < 220; i++) begin
            if (p == 1 && i == 20) hold_rsp = 1;
            send_random(!(p == 3 && i < 40));
         end
         wait_idle();
      end

      $display("covered %0d requests and %0d results over four gain/period settings",
               sent_count, result_count);
      if (fail_count == 0)
         $display("quat_axis_angle_spin_control_top_test: PASS");
      else
         $display("quat_axis_angle_spin_control_top_test: FAIL");
      $finish;
   end
endmodule
